>>> rtl/core/wls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_pkg
// Shared constants, codes and control types for the window slope block.
// ----------------------------------------------------------------------------
package wls_pkg;

  // Window geometry.
  localparam int HistDepth = 16;
  localparam int AddrW     = 4;
  localparam int CntW      = 5;

  // Field and accumulator widths.
  localparam int ValW   = 24;
  localparam int TimeW  = 32;
  localparam int SlopeW = 32;
  localparam int SxW    = 37;
  localparam int SyW    = 29;
  localparam int SxyW   = 61;
  localparam int SxxW   = 68;
  localparam int WideW  = 96;

  // Serial multiplier bit count and step counter width.
  localparam int MulBits = 37;
  localparam int StepW   = 7;

  // Milliseconds per minute.
  localparam logic [MulBits-1:0] ScaleFactor = MulBits'(60000);

  // Multiplier operations, in the order the controller runs them.
  typedef logic [2:0] mul_op_t;
  localparam mul_op_t MulNsxx  = 3'd0;
  localparam mul_op_t MulSxSx  = 3'd1;
  localparam mul_op_t MulNsxy  = 3'd2;
  localparam mul_op_t MulSxSy  = 3'd3;
  localparam mul_op_t MulScale = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            ring_wr;
    logic            rd_en;
    logic [CntW-1:0] rd_idx;
    logic            acc_en;
    logic            acc_first;
    logic            mul_load;
    logic            mul_step;
    logic            mul_store;
    mul_op_t         mul_op;
    logic            div_load;
    logic            div_step;
    logic            res_load;
    logic            res_zero;
  } wls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CntW-1:0] fill;
    logic            den_zero;
  } wls_stat_t;

endpackage

>>> rtl/core/wls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_ctrl
// Sequencer: walks the window, runs the multiplies and the division.
// ----------------------------------------------------------------------------
module wls_ctrl import wls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  wls_stat_t stat_i,
  output wls_cmd_t  cmd_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SChk    = 4'd1;
  localparam logic [3:0] SRd     = 4'd2;
  localparam logic [3:0] SAc     = 4'd3;
  localparam logic [3:0] SMLoad  = 4'd4;
  localparam logic [3:0] SMStep  = 4'd5;
  localparam logic [3:0] SMStore = 4'd6;
  localparam logic [3:0] SDLoad  = 4'd7;
  localparam logic [3:0] SDStep  = 4'd8;
  localparam logic [3:0] SDone   = 4'd9;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  mul_op_t         op_q, op_d;
  logic            zero_q, zero_d;
  logic            oval_q, oval_d;
  logic            accept;
  logic            out_free;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = oval_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !oval_q || out_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    zero_d  = zero_q;
    oval_d  = oval_q;
    cmd_o   = '0;
    cmd_o.rd_idx = idx_q;
    cmd_o.mul_op = op_q;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_o.ring_wr = 1'b1;
          zero_d  = 1'b0;
          state_d = SChk;
        end
      end
      SChk: begin
        idx_d = '0;
        if (stat_i.fill < CntW'(2)) begin
          zero_d  = 1'b1;
          state_d = SDone;
        end else begin
          state_d = SRd;
        end
      end
      SRd: begin
        cmd_o.rd_en = 1'b1;
        state_d = SAc;
      end
      SAc: begin
        cmd_o.acc_en    = 1'b1;
        cmd_o.acc_first = (idx_q == '0);
        idx_d = idx_q + CntW'(1);
        if (idx_q == stat_i.fill - CntW'(1)) begin
          op_d    = MulNsxx;
          state_d = SMLoad;
        end else begin
          state_d = SRd;
        end
      end
      SMLoad: begin
        cmd_o.mul_load = 1'b1;
        cnt_d   = '0;
        state_d = SMStep;
      end
      SMStep: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(MulBits - 1)) begin
          state_d = SMStore;
        end
      end
      SMStore: begin
        cmd_o.mul_store = 1'b1;
        if (op_q == MulScale) begin
          state_d = SDLoad;
        end else begin
          op_d    = op_q + mul_op_t'(1);
          state_d = SMLoad;
        end
      end
      SDLoad: begin
        cmd_o.div_load = 1'b1;
        cnt_d   = '0;
        state_d = SDStep;
      end
      SDStep: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(WideW - 1)) begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_zero = zero_q || stat_i.den_zero;
          oval_d  = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      cnt_q   <= '0;
      op_q    <= MulNsxx;
      zero_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
      zero_q  <= zero_d;
      oval_q  <= oval_d;
    end
  end

endmodule

>>> rtl/core/wls_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wls_datapath
// Sample ring, window sums, serial multiplier, restoring divider, result.
// ----------------------------------------------------------------------------
module wls_datapath import wls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wls_cmd_t          cmd_i,
  output wls_stat_t         stat_o,
  input  logic [ValW-1:0]   sample_value_i,
  input  logic [TimeW-1:0]  sample_time_ms_i,
  output logic [SlopeW-1:0] slope_per_minute_o,
  output logic              slope_valid_o,
  output logic              slope_saturated_o,
  output logic [CntW-1:0]   samples_held_o
);

  logic [ValW-1:0]  val_mem  [HistDepth];
  logic [TimeW-1:0] time_mem [HistDepth];
  logic [AddrW-1:0] wslot_q;
  logic [CntW-1:0]  fill_q;
  logic [AddrW-1:0] first;
  logic [AddrW-1:0] rd_addr;
  logic [ValW-1:0]  rd_val_q;
  logic [TimeW-1:0] rd_time_q;
  logic [TimeW-1:0] t0_q;

  logic [TimeW-1:0]      x_w;
  logic signed [56:0]    prod_xy;
  logic [63:0]           prod_xx;
  logic [SxW-1:0]        sx_q;
  logic signed [SyW-1:0] sy_q;
  logic signed [SxyW-1:0] sxy_q;
  logic [SxxW-1:0]       sxx_q;

  logic [WideW-1:0]   mcand_q, acc_q, tmp_q, den_q, num_q;
  logic [MulBits-1:0] mplier_q;
  logic [WideW-1:0]   a_sel;
  logic [MulBits-1:0] b_sel;

  logic [WideW-1:0] dvd_q, rem_q, quo_q;
  logic             neg_q;
  logic [WideW:0]   rem_sh;
  logic             fits;

  logic             sat_pos, sat_neg;

  assign first   = wslot_q - fill_q[AddrW-1:0];
  assign rd_addr = first + cmd_i.rd_idx[AddrW-1:0];
  assign stat_o.fill     = fill_q;
  assign stat_o.den_zero = (den_q == '0);

  // Ring write pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q <= '0;
      fill_q  <= '0;
    end else if (cmd_i.ring_wr) begin
      wslot_q <= wslot_q + AddrW'(1);
      if (fill_q < CntW'(HistDepth)) begin
        fill_q <= fill_q + CntW'(1);
      end
    end
  end

  // Sample ring memory with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_wr) begin
      val_mem[wslot_q]  <= sample_value_i;
      time_mem[wslot_q] <= sample_time_ms_i;
    end
    if (cmd_i.rd_en) begin
      rd_val_q  <= val_mem[rd_addr];
      rd_time_q <= time_mem[rd_addr];
    end
  end

  // Per-sample terms; the oldest sample has offset zero.
  assign x_w     = cmd_i.acc_first ? '0 : rd_time_q - t0_q;
  assign prod_xy = $signed({1'b0, x_w}) * $signed(rd_val_q);
  assign prod_xx = x_w * x_w;

  // Window sums.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_wr) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (cmd_i.acc_first) begin
        t0_q <= rd_time_q;
      end
      sx_q  <= sx_q + SxW'(x_w);
      sy_q  <= sy_q + SyW'($signed(rd_val_q));
      sxy_q <= sxy_q + SxyW'(prod_xy);
      sxx_q <= sxx_q + SxxW'(prod_xx);
    end
  end

  // Multiplier operand selection.
  always_comb begin
    case (cmd_i.mul_op)
      MulNsxx: begin
        a_sel = WideW'(sxx_q);
        b_sel = MulBits'(fill_q);
      end
      MulSxSx: begin
        a_sel = WideW'(sx_q);
        b_sel = MulBits'(sx_q);
      end
      MulNsxy: begin
        a_sel = WideW'(sxy_q);
        b_sel = MulBits'(fill_q);
      end
      MulSxSy: begin
        a_sel = WideW'(sy_q);
        b_sel = MulBits'(sx_q);
      end
      MulScale: begin
        a_sel = num_q;
        b_sel = ScaleFactor;
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  // Shift-and-add multiplier, one multiplier bit a cycle, modulo 2^WideW.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mcand_q  <= a_sel;
      mplier_q <= b_sel;
      acc_q    <= '0;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[WideW-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[MulBits-1:1]};
    end
  end

  // Combine products into denominator and numerator.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_store) begin
      case (cmd_i.mul_op)
        MulNsxx:  tmp_q <= acc_q;
        MulSxSx:  den_q <= tmp_q - acc_q;
        MulNsxy:  tmp_q <= acc_q;
        MulSxSy:  num_q <= tmp_q - acc_q;
        MulScale: num_q <= acc_q;
        default:  tmp_q <= tmp_q;
      endcase
    end
  end

  // Restoring divider on the numerator magnitude, one quotient bit a cycle.
  assign rem_sh = {rem_q, dvd_q[WideW-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      neg_q <= num_q[WideW-1];
      dvd_q <= num_q[WideW-1] ? (~num_q + WideW'(1)) : num_q;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[WideW-2:0], 1'b0};
      if (fits) begin
        rem_q <= WideW'(rem_sh - {1'b0, den_q});
      end else begin
        rem_q <= rem_sh[WideW-1:0];
      end
      quo_q <= {quo_q[WideW-2:0], fits};
    end
  end

  // Saturation against the signed output range.
  assign sat_pos = |quo_q[WideW-1:SlopeW-1];
  assign sat_neg = (|quo_q[WideW-1:SlopeW]) ||
                   (quo_q[SlopeW-1] && (|quo_q[SlopeW-2:0]));

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      samples_held_o <= fill_q;
      if (cmd_i.res_zero) begin
        slope_per_minute_o <= '0;
        slope_valid_o      <= 1'b0;
        slope_saturated_o  <= 1'b0;
      end else begin
        slope_valid_o <= 1'b1;
        if (!neg_q) begin
          slope_saturated_o  <= sat_pos;
          slope_per_minute_o <= sat_pos ? {1'b0, {(SlopeW-1){1'b1}}} : quo_q[SlopeW-1:0];
        end else begin
          slope_saturated_o  <= sat_neg;
          slope_per_minute_o <= sat_neg ? {1'b1, {(SlopeW-1){1'b0}}}
                                        : SlopeW'(0) - quo_q[SlopeW-1:0];
        end
      end
    end
  end

endmodule

>>> rtl/core/window_least_squares_slope_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_least_squares_slope_top
// Least-squares slope per minute over a ring of the newest 16 samples.
// ----------------------------------------------------------------------------
// When 2 or more samples are held, the sequencer reads and sums each of them, then runs
// five serial multiplies and the 96-step restoring divider; one word in flight at a time.
// A new word is taken while the previous result waits in the output register.
// Reset clears the controller, write slot and fill count; the ring is not cleared.
module window_least_squares_slope_top import wls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              sample_valid_i,
  output logic              sample_ready_o,
  input  logic [ValW-1:0]   sample_value_i,
  input  logic [TimeW-1:0]  sample_time_ms_i,
  output logic              result_valid_o,
  input  logic              result_ready_i,
  output logic [SlopeW-1:0] slope_per_minute_o,
  output logic              slope_valid_o,
  output logic              slope_saturated_o,
  output logic [CntW-1:0]   samples_held_o
);

  wls_cmd_t  cmd;
  wls_stat_t stat;

  // Sequencer.
  wls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_valid_i),
    .in_ready_o  (sample_ready_o),
    .out_valid_o (result_valid_o),
    .out_ready_i (result_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  wls_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .sample_value_i     (sample_value_i),
    .sample_time_ms_i   (sample_time_ms_i),
    .slope_per_minute_o (slope_per_minute_o),
    .slope_valid_o      (slope_valid_o),
    .slope_saturated_o  (slope_saturated_o),
    .samples_held_o     (samples_held_o)
  );

endmodule
